@@ rtl/core/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the 2x2 box-filter RGBA mip downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int PIX_W          = 8;
	localparam int CHAN_SUM_W     = 10;
	localparam int SIZE_W         = 13;
	localparam int ROW_W          = 12;
	localparam int MIN_SIZE       = 2;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int SIZE_RESET     = 256;
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
		logic [PIX_W-1:0] in_alpha;
	} src_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_alpha;
		logic             frame_end;
	} dst_pixel_t;

	typedef struct packed {
		logic [CHAN_SUM_W-1:0] red;
		logic [CHAN_SUM_W-1:0] green;
		logic [CHAN_SUM_W-1:0] blue;
		logic [CHAN_SUM_W-1:0] alpha;
	} pair_sum_t;

	// one request after the position stage
	typedef struct packed {
		logic      valid;
		logic      emit;       // odd column, odd row: produces an output pixel
		logic      store;      // odd column, even row: writes the line store
		logic      frame_end;
		pair_sum_t sums;
	} stage_t;

endpackage

@@ rtl/core/rbd_ram.sv @@
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbd_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/rbd_cfg.sv @@
// ----------------------------------------------------------------------------
// rbd_cfg
// APB register file for the source size, with clamping to the legal range.
// ----------------------------------------------------------------------------
module rbd_cfg #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
	localparam int WX_W     = $clog2(MAX_WIDTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [WX_W-1:0]                 width_eff,
	output logic [rbd_pkg::SIZE_W-1:0]      height_eff
);

	logic [rbd_pkg::SIZE_W-1:0] width_q;
	logic [rbd_pkg::SIZE_W-1:0] height_q;
	rbd_pkg::reg_idx_t          idx;
	logic                       wr;

	assign pready = 1'b1;
	assign idx    = rbd_pkg::reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbd_pkg::SIZE_W'(rbd_pkg::SIZE_RESET);
			height_q <= rbd_pkg::SIZE_W'(rbd_pkg::SIZE_RESET);
		end else if (wr) begin
			unique case (idx)
				rbd_pkg::REG_SRC_WIDTH:  width_q  <= pwdata[rbd_pkg::SIZE_W-1:0];
				rbd_pkg::REG_SRC_HEIGHT: height_q <= pwdata[rbd_pkg::SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rbd_pkg::REG_SRC_WIDTH:  prdata = rbd_pkg::APB_DATA_W'(width_q);
			rbd_pkg::REG_SRC_HEIGHT: prdata = rbd_pkg::APB_DATA_W'(height_q);
		endcase
	end

	always_comb begin
		if (32'(width_q) < rbd_pkg::MIN_SIZE) begin
			width_eff = WX_W'(rbd_pkg::MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_eff = WX_W'(MAX_WIDTH);
		end else begin
			width_eff = WX_W'(width_q);
		end
	end

	always_comb begin
		if (32'(height_q) < rbd_pkg::MIN_SIZE) begin
			height_eff = rbd_pkg::SIZE_W'(rbd_pkg::MIN_SIZE);
		end else if (32'(height_q) > rbd_pkg::HEIGHT_LIMIT) begin
			height_eff = rbd_pkg::SIZE_W'(rbd_pkg::HEIGHT_LIMIT);
		end else begin
			height_eff = height_q;
		end
	end

endmodule

@@ rtl/core/rbd_front.sv @@
// ----------------------------------------------------------------------------
// rbd_front
// Column/row tracking, held left pixel, horizontal pair sums and stage 1.
// ----------------------------------------------------------------------------
module rbd_front #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
	localparam int WX_W     = $clog2(MAX_WIDTH + 1),
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int ADDR_W   = $clog2(MAX_WIDTH / 2)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        leave,
	input  rbd_pkg::src_pixel_t         src_data,
	input  logic [WX_W-1:0]             width_eff,
	input  logic [rbd_pkg::SIZE_W-1:0]  height_eff,
	output rbd_pkg::stage_t             stage_s1,
	output logic [ADDR_W-1:0]           slot_s1,
	output logic                        rd_en,
	output logic [ADDR_W-1:0]           rd_addr
);

	logic [COL_W-1:0]           col_q;
	logic [rbd_pkg::ROW_W-1:0]  row_q;
	rbd_pkg::src_pixel_t        held_q;

	logic [WX_W-1:0]            col_cur;
	logic [WX_W-1:0]            col_inc;
	logic [WX_W-1:0]            slot_full;
	logic [WX_W-1:0]            last_col;
	logic [rbd_pkg::SIZE_W-1:0] row_cur;
	logic [rbd_pkg::SIZE_W-1:0] row_inc;
	logic [rbd_pkg::SIZE_W-1:0] last_row;
	logic [COL_W-1:0]           col_d;
	logic [rbd_pkg::ROW_W-1:0]  row_d;
	rbd_pkg::stage_t            stage_d;

	always_comb begin
		col_cur = WX_W'(col_q);
		row_cur = rbd_pkg::SIZE_W'(row_q);
		// wrap first if a size change left the counters past the end
		if (col_cur >= width_eff) begin
			col_cur = '0;
			row_cur = row_cur + 1'b1;
		end
		if (row_cur >= height_eff) begin
			row_cur = '0;
		end

		col_inc = col_cur + 1'b1;
		row_inc = row_cur + 1'b1;
		if (col_inc >= width_eff) begin
			col_d = '0;
			row_d = (row_inc >= height_eff) ? '0 : row_inc[rbd_pkg::ROW_W-1:0];
		end else begin
			col_d = col_inc[COL_W-1:0];
			row_d = row_cur[rbd_pkg::ROW_W-1:0];
		end

		slot_full = col_cur >> 1;
		last_col  = {width_eff[WX_W-1:1], 1'b0} - 1'b1;
		last_row  = {height_eff[rbd_pkg::SIZE_W-1:1], 1'b0} - 1'b1;

		stage_d.valid      = 1'b1;
		stage_d.emit       = col_cur[0] && row_cur[0];
		stage_d.store      = col_cur[0] && !row_cur[0];
		stage_d.frame_end  = (col_cur == last_col) && (row_cur == last_row);
		stage_d.sums.red   = rbd_pkg::CHAN_SUM_W'(held_q.in_red)
		                   + rbd_pkg::CHAN_SUM_W'(src_data.in_red);
		stage_d.sums.green = rbd_pkg::CHAN_SUM_W'(held_q.in_green)
		                   + rbd_pkg::CHAN_SUM_W'(src_data.in_green);
		stage_d.sums.blue  = rbd_pkg::CHAN_SUM_W'(held_q.in_blue)
		                   + rbd_pkg::CHAN_SUM_W'(src_data.in_blue);
		stage_d.sums.alpha = rbd_pkg::CHAN_SUM_W'(held_q.in_alpha)
		                   + rbd_pkg::CHAN_SUM_W'(src_data.in_alpha);
	end

	// fetch the pair sums of the row above for the right pixel of an odd row
	assign rd_en   = accept && stage_d.emit;
	assign rd_addr = slot_full[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
			if (!col_cur[0]) begin
				held_q <= src_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (accept) begin
			stage_s1 <= stage_d;
		end else if (leave) begin
			stage_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1 <= slot_full[ADDR_W-1:0];
		end
	end

endmodule

@@ rtl/core/rbd_back.sv @@
// ----------------------------------------------------------------------------
// rbd_back
// Vertical add with the line store, divide by four and the output register.
// ----------------------------------------------------------------------------
module rbd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rbd_pkg::stage_t     stage_s1,
	input  rbd_pkg::pair_sum_t  above,
	input  logic                dst_stall,
	output logic                dst_valid,
	output rbd_pkg::dst_pixel_t dst_data,
	output logic                leave,
	output logic                wr_en
);

	localparam int TOTAL_W = rbd_pkg::CHAN_SUM_W + 1;

	logic                dst_valid_q;
	rbd_pkg::dst_pixel_t dst_data_q;
	rbd_pkg::dst_pixel_t avg;
	logic [TOTAL_W-1:0]  tot_red;
	logic [TOTAL_W-1:0]  tot_green;
	logic [TOTAL_W-1:0]  tot_blue;
	logic [TOTAL_W-1:0]  tot_alpha;

	// a non-emitting request retires at once; an emitting one needs a free output slot
	assign leave = stage_s1.valid && (!stage_s1.emit || !dst_valid_q || !dst_stall);
	assign wr_en = leave && stage_s1.store;

	always_comb begin
		tot_red   = TOTAL_W'(stage_s1.sums.red)   + TOTAL_W'(above.red);
		tot_green = TOTAL_W'(stage_s1.sums.green) + TOTAL_W'(above.green);
		tot_blue  = TOTAL_W'(stage_s1.sums.blue)  + TOTAL_W'(above.blue);
		tot_alpha = TOTAL_W'(stage_s1.sums.alpha) + TOTAL_W'(above.alpha);
		avg.out_red   = tot_red[TOTAL_W-2:2];
		avg.out_green = tot_green[TOTAL_W-2:2];
		avg.out_blue  = tot_blue[TOTAL_W-2:2];
		avg.out_alpha = tot_alpha[TOTAL_W-2:2];
		avg.frame_end = stage_s1.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (leave && stage_s1.emit) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave && stage_s1.emit) begin
			dst_data_q <= avg;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

endmodule

@@ rtl/core/rgba_box_downsample_2x2.sv @@
// Stage 1 and the output register lie between an odd-row right pixel and its result.
// Throughput: one source pixel per clock unless a stalled result holds stage 1; results
// on one pixel in four (odd row, odd column). The registered line store read starts on entry.
// Reset: counters, held pixel and pipeline valids clear; both size registers return to 256.
// The line store is not cleared; every entry is written on an even row before it is read.
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// 2x2 box-filter mip downsampler for a raster stream of RGBA8 pixels.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2 #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rbd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rbd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rbd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  rbd_pkg::src_pixel_t            src_data,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output rbd_pkg::dst_pixel_t            dst_data
);

	localparam int WX_W       = $clog2(MAX_WIDTH + 1);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);

	logic [WX_W-1:0]            width_eff;
	logic [rbd_pkg::SIZE_W-1:0] height_eff;
	logic                       accept;
	logic                       leave;
	rbd_pkg::stage_t            stage_s1;
	logic [ADDR_W-1:0]          slot_s1;
	logic                       rd_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       wr_en;
	rbd_pkg::pair_sum_t         above;

	assign src_stall = stage_s1.valid && !leave;
	assign accept    = src_valid && !src_stall;

	rbd_cfg #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.width_eff (width_eff),
		.height_eff(height_eff)
	);

	rbd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.leave     (leave),
		.src_data  (src_data),
		.width_eff (width_eff),
		.height_eff(height_eff),
		.stage_s1  (stage_s1),
		.slot_s1   (slot_s1),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	rbd_ram #(
		.WIDTH($bits(rbd_pkg::pair_sum_t)),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot_s1),
		.wr_data(stage_s1.sums),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(above)
	);

	rbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.above    (above),
		.dst_stall(dst_stall),
		.dst_valid(dst_valid),
		.dst_data (dst_data),
		.leave    (leave),
		.wr_en    (wr_en)
	);

endmodule

@@ rtl/core/rbd_chk.sv @@
// ----------------------------------------------------------------------------
// rbd_chk
// Port-level checks for the 2x2 box-filter downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [rbd_pkg::APB_ADDR_W-1:0] paddr,
	input logic [rbd_pkg::APB_DATA_W-1:0] pwdata,
	input logic [rbd_pkg::APB_DATA_W-1:0] prdata,
	input logic                           pready,
	input logic                           src_valid,
	input logic                           src_stall,
	input logic                           dst_valid,
	input logic                           dst_stall,
	input rbd_pkg::dst_pixel_t            dst_data
);

	// hold a stalled result
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled result changed or dropped");

	// a new result traces back through the output and stage 1 registers to an accepted request
	a_dst_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(src_valid && !src_stall, 2))
		else $error("result appeared without a matching request");

	// the source side only stalls behind a stalled result
	a_src_stall: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall)
		else $error("source stalled while the output was free");

	// a width write reads back on the next cycle
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2]
		|=> pwrite || paddr[2]
		    || (prdata[12:0] == $past(pwdata[12:0]) && prdata[31:13] == 19'd0))
		else $error("source width readback mismatch");

endmodule

bind rgba_box_downsample_2x2 rbd_chk u_chk (.*);
